// ===== rtl/sbf_pkg.sv =====
// ============================================================================
// sbf_pkg
// Shared types and constants of the frame decoder.
// ============================================================================
package sbf_pkg;

  localparam int FRAME_BYTES_DEF = 28;
  localparam int CHANNELS_DEF    = 16;

  localparam logic [7:0] HDR_BYTE   = 8'h0F;
  localparam int         FLAG_BYTE  = 23;
  localparam int         MIN_LEN    = 23;
  localparam int         FS_BIT     = 3;
  localparam int         LOST_BIT   = 2;
  localparam int         ANY_FIRST  = 1;
  localparam int         ANY_LAST   = 6;
  localparam int         PRE_STEPS  = ANY_LAST + 2;
  localparam int         RAW_OFFSET = 992;

  localparam logic [15:0] GAP_RESET  = 16'd1000;
  localparam logic [7:0]  HOLD_RESET = 8'd100;

  localparam logic CFG_GAP  = 1'b0;
  localparam logic CFG_HOLD = 1'b1;

  typedef struct packed {
    logic start;
    logic len_ok;
  } dec_req_t;

  typedef struct packed {
    logic              frame_ok;
    logic [3:0]        channel_index;
    logic signed [10:0] channel_value;
    logic              failsafe_flag;
    logic              lost_flag;
    logic [7:0]        valid_count;
    logic              last_result;
  } result_t;

endpackage

// ===== rtl/sbf_frame_mem.sv =====
// ============================================================================
// sbf_frame_mem
// Frame byte store with one write port and one registered read port.
// Entries never written since reset read as zero.
// ============================================================================
module sbf_frame_mem #(
  parameter int FRAME_BYTES = sbf_pkg::FRAME_BYTES_DEF,
  parameter int AW          = $clog2(FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]             mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] valid_r;
  logic [7:0]             q_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? q_r : 8'd0;

endmodule

// ===== rtl/sbf_decoder.sv =====
// ============================================================================
// sbf_decoder
// Frame close sequencer: reads header, flags and presence bytes; rejects bad
// frames, else updates the validity hold and emits scaled per-channel values.
// ============================================================================
module sbf_decoder #(
  parameter int FRAME_BYTES = sbf_pkg::FRAME_BYTES_DEF,
  parameter int CHANNELS    = sbf_pkg::CHANNELS_DEF,
  parameter int AW          = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbf_pkg::dec_req_t req,
  input  logic [7:0]        hold_value,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output sbf_pkg::result_t  res
);
  import sbf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PRE    = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_CHAN   = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [3:0] k_r, k_nxt;
  logic [1:0] j_r, j_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       hdr_ok_r, hdr_ok_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [7:0] any_r, any_nxt;
  logic [7:0] w0_r, w0_nxt;
  logic [7:0] w1_r, w1_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r, out_nxt;

  logic               slot_free;
  logic               fs;
  logic               lost;
  logic [7:0]         bitpos;
  logic [23:0]        win;
  logic [10:0]        raw;
  logic signed [11:0] diff;
  logic signed [14:0] diff_x;
  logic signed [14:0] prod;
  logic signed [14:0] quot;

  assign slot_free = !out_valid_r || res_ready;
  assign fs        = flags_r[FS_BIT];
  assign lost      = flags_r[LOST_BIT];
  assign busy      = (state_r != ST_IDLE);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  // Channel k starts at bit 8 + 11k of the store.
  assign bitpos = 8'd8 + 8'(k_r) * 8'd11;
  assign win    = {rd_data, w1_r, w0_r};
  assign raw    = 11'(win >> bitpos[2:0]);
  assign diff   = $signed({1'b0, raw}) - 12'sd992;
  assign diff_x = 15'(diff);
  assign prod   = (diff_x <<< 2) + diff_x;
  assign quot   = prod[14] ? ((prod + 15'sd7) >>> 3) : (prod >>> 3);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    len_ok_nxt    = len_ok_r;
    hdr_ok_nxt    = hdr_ok_r;
    flags_nxt     = flags_r;
    any_nxt       = any_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_ready;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          state_nxt  = ST_PRE;
          step_nxt   = 4'd0;
          len_ok_nxt = req.len_ok;
          any_nxt    = 8'd0;
        end
      end
      ST_PRE: begin
        if (step_r < 4'(PRE_STEPS)) begin
          rd_en = 1'b1;
          if (step_r == 4'd0) begin
            rd_addr = '0;
          end else if (step_r == 4'd1) begin
            rd_addr = AW'(FLAG_BYTE);
          end else begin
            rd_addr = AW'(step_r - 4'd1);
          end
        end
        if (step_r == 4'd1) begin
          hdr_ok_nxt = (rd_data == HDR_BYTE) && len_ok_r;
        end else if (step_r == 4'd2) begin
          flags_nxt = rd_data;
        end else if (step_r > 4'd2) begin
          any_nxt = any_r | rd_data;
        end
        if (step_r == 4'(PRE_STEPS)) begin
          state_nxt = ST_DECIDE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DECIDE: begin
        if (!hdr_ok_r) begin
          if (slot_free) begin
            out_nxt               = '0;
            out_nxt.valid_count   = hold_r;
            out_nxt.last_result   = 1'b1;
            out_valid_nxt         = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end else begin
          if (fs || any_r == 8'd0) begin
            hold_nxt = (hold_r != 8'd0) ? 8'd1 : 8'd0;
          end else if (!lost) begin
            hold_nxt = hold_value;
          end
          k_nxt     = 4'd0;
          j_nxt     = 2'd0;
          state_nxt = ST_CHAN;
        end
      end
      ST_CHAN: begin
        if (j_r != 2'd3) begin
          rd_en   = 1'b1;
          rd_addr = AW'({3'b000, bitpos[7:3]}) + AW'(j_r);
          j_nxt   = j_r + 2'd1;
        end
        if (j_r == 2'd1) begin
          w0_nxt = rd_data;
        end else if (j_r == 2'd2) begin
          w1_nxt = rd_data;
        end else if (j_r == 2'd3 && slot_free) begin
          out_nxt.frame_ok      = 1'b1;
          out_nxt.channel_index = k_r;
          out_nxt.channel_value = quot[10:0];
          out_nxt.failsafe_flag = fs;
          out_nxt.lost_flag     = lost;
          out_nxt.valid_count   = hold_r;
          out_nxt.last_result   = (k_r == 4'(CHANNELS - 1));
          out_valid_nxt         = 1'b1;
          j_nxt                 = 2'd0;
          k_nxt                 = k_r + 4'd1;
          if (k_r == 4'(CHANNELS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      k_r         <= 4'd0;
      j_r         <= 2'd0;
      len_ok_r    <= 1'b0;
      hdr_ok_r    <= 1'b0;
      hold_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      len_ok_r    <= len_ok_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    any_r   <= any_nxt;
    w0_r    <= w0_nxt;
    w1_r    <= w1_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== rtl/sbus_frame_decoder_top.sv =====
// ============================================================================
// sbus_frame_decoder_top
// Serial receive frame decoder with idle gap framing and channel scaling.
// ============================================================================
// A received byte or a time tick is taken whenever in_tready is high. A tick
// that closes a frame starts the decode sequencer, which holds in_tready low
// until it has handed its last item to the output register; its pace is set
// by the single read port of the frame store, which serves one byte per
// cycle, and by output stalls. Per-entry valid bits make unwritten store
// bytes read as zero, so no clearing pass follows reset. Output items wait
// in a register while input is taken.
module sbus_frame_decoder_top #(
  parameter int FRAME_BYTES = sbf_pkg::FRAME_BYTES_DEF,
  parameter int CHANNELS    = sbf_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // channel_index, channel_value, failsafe_flag, lost_flag, valid_count
  output logic [31:0] out_tdata,
  output logic        out_tuser,  // frame_ok
  output logic        out_tlast,  // last_result
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sbf_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

  logic [15:0]   gap_r;
  logic [7:0]    hold_value_r;
  logic [AW-1:0] wi_r, wi_nxt;
  logic [15:0]   idle_r, idle_nxt;
  logic [15:0]   idle_inc;
  logic          accept;
  logic          busy;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  dec_req_t      req;
  result_t       res;

  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;
  assign wr_en     = accept && !in_tuser;
  assign idle_inc  = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  always_comb begin
    wi_nxt     = wi_r;
    idle_nxt   = idle_r;
    req.start  = 1'b0;
    req.len_ok = (wi_r >= AW'(MIN_LEN));
    if (accept) begin
      if (!in_tuser) begin
        wi_nxt   = (wi_r == LAST_IDX) ? LAST_IDX : wi_r + AW'(1);
        idle_nxt = 16'd0;
      end else if (wi_r != '0 && idle_inc > gap_r) begin
        req.start = 1'b1;
        wi_nxt    = '0;
        idle_nxt  = 16'd0;
      end else begin
        idle_nxt = idle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r         <= '0;
      idle_r       <= 16'd0;
      gap_r        <= GAP_RESET;
      hold_value_r <= HOLD_RESET;
    end else begin
      wi_r   <= wi_nxt;
      idle_r <= idle_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GAP:  gap_r        <= cfg_wdata;
          CFG_HOLD: hold_value_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  sbf_frame_mem #(
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wi_r),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbf_decoder #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS),
    .AW          (AW)
  ) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .hold_value (hold_value_r),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {7'b0, res.valid_count, res.lost_flag, res.failsafe_flag,
                      res.channel_value, res.channel_index};
  assign out_tuser = res.frame_ok;
  assign out_tlast = res.last_result;

endmodule

// ===== verif/sbus_frame_decoder_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sbus_frame_decoder_top_test
// Self-checking testbench for the serial receive frame decoder. A short
// table of directed frames is followed by random frames with random
// content, under several pacing modes and register settings. Each accepted
// item is fed to a predictor of the frame store, gap timer and validity
// hold, and every result is compared field by field with the oldest
// expected result.
// ============================================================================
module sbus_frame_decoder_top_test;
  import sbf_pkg::*;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam int LAST_ENTRY = FRAME_BYTES_DEF - 1;
  localparam int SETTLE_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int PHASE_ITEMS = 1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // rx_byte
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // channel_index, channel_value, failsafe_flag, lost_flag, valid_count
  logic        out_tuser;  // frame_ok
  logic        out_tlast;  // last_result
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  logic [7:0]  frame_bytes [FRAME_BYTES_DEF];
  int          fill_idx;
  logic [15:0] idle_ticks;
  logic [7:0]  hold_count;
  logic [15:0] gap_limit;
  logic [7:0]  hold_load;

  result_t     frame_results[$];
  result_t     pending_results[$];
  stim_row_t   dir_table[$];
  logic        row_typed;
  result_t     row_want;

  int good_frames;
  int rejected_frames;
  int items_in;
  int results_out;
  int mismatches;
  int quiet_cycles;
  int hold_off;
  int send_idle_pct;
  int recv_stall_pct;

  sbus_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t reject_result(input logic [7:0] hold);
    result_t r;
    r = '0;
    r.valid_count = hold;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic m, input logic [7:0] d,
                                         input logic typed, input result_t want);
    stim_row_t s;
    s.mode = m;
    s.data = d;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic decode_step(input logic m, input logic [7:0] b);
    int i;
    int k;
    int bitpos;
    int bi;
    int raw;
    int v;
    logic [23:0] w;
    logic [7:0] any_bits;
    logic fs;
    logic lost;
    result_t r;
    begin
      frame_results.delete();
      if (m == MODE_BYTE) begin
        i = (fill_idx > LAST_ENTRY) ? LAST_ENTRY : fill_idx;
        frame_bytes[i] = b;
        i++;
        if (i > LAST_ENTRY) i = LAST_ENTRY;
        fill_idx = i;
        idle_ticks = '0;
      end else begin
        if (idle_ticks != 16'hFFFF) idle_ticks++;
        if (fill_idx != 0 && idle_ticks > gap_limit) begin
          if (frame_bytes[0] != HDR_BYTE || fill_idx < MIN_LEN) begin
            frame_results.push_back(reject_result(hold_count));
            rejected_frames++;
          end else begin
            fs = frame_bytes[FLAG_BYTE][FS_BIT];
            lost = frame_bytes[FLAG_BYTE][LOST_BIT];
            any_bits = '0;
            for (i = ANY_FIRST; i <= ANY_LAST; i++) any_bits |= frame_bytes[i];
            if (fs || any_bits == 8'h00) begin
              if (hold_count != 8'h00) hold_count = 8'd1;
            end else if (!lost) begin
              hold_count = hold_load;
            end
            for (k = 0; k < CHANNELS_DEF; k++) begin
              bitpos = 8 + 11 * k;
              bi = bitpos / 8;
              w = {frame_bytes[bi + 2], frame_bytes[bi + 1], frame_bytes[bi]};
              raw = int'((w >> (bitpos % 8)) & 24'h0007FF);
              v = ((raw - RAW_OFFSET) * 5) / 8;
              r.frame_ok = 1'b1;
              r.channel_index = k[3:0];
              r.channel_value = v[10:0];
              r.failsafe_flag = fs;
              r.lost_flag = lost;
              r.valid_count = hold_count;
              r.last_result = (k == CHANNELS_DEF - 1);
              frame_results.push_back(r);
            end
            good_frames++;
          end
          fill_idx = 0;
          idle_ticks = '0;
        end
      end
    end
  endtask

  task automatic push_item(input logic m, input logic [7:0] b);
    begin
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser <= m;
      in_tdata <= b;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      items_in++;
      decode_step(m, b);
      if (row_typed) pending_results.push_back(row_want);
      else foreach (frame_results[j]) pending_results.push_back(frame_results[j]);
      @(negedge clk);
    end
  endtask

  task automatic set_config(input logic [15:0] gap, input logic [7:0] hold);
    begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_GAP;
      cfg_wdata <= gap;
      @(negedge clk);
      cfg_index <= CFG_HOLD;
      cfg_wdata <= {8'($urandom_range(0, 255)), hold};
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      gap_limit = gap;
      hold_load = hold;
    end
  endtask

  task automatic settle();
    begin
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      @(negedge clk);
    end
  endtask

  task automatic send_frame();
    int kind;
    int len;
    int j;
    logic zero_head;
    logic [7:0] b;
    begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 32)
                                          : $urandom_range(MIN_LEN, FRAME_BYTES_DEF);
        zero_head = ($urandom_range(0, 5) == 0);
        push_item(MODE_BYTE, HDR_BYTE);
        for (j = 1; j < len; j++) begin
          b = 8'($urandom_range(0, 255));
          if (zero_head && j <= ANY_LAST) b = 8'h00;
          if (j == FLAG_BYTE && $urandom_range(0, 1) == 0) b &= 8'hF3;
          push_item(MODE_BYTE, b);
        end
        if (kind == 6) begin
          repeat ($urandom_range(1, gap_limit))
            push_item(MODE_TICK, 8'($urandom_range(0, 255)));
          repeat ($urandom_range(1, 3)) push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
      end else if (kind == 7) begin
        b = 8'($urandom_range(0, 255));
        if (b == HDR_BYTE) b = ~b;
        push_item(MODE_BYTE, b);
        repeat ($urandom_range(0, LAST_ENTRY))
          push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        push_item(MODE_BYTE, HDR_BYTE);
        repeat ($urandom_range(0, MIN_LEN - 2))
          push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) push_item(MODE_TICK, 8'($urandom_range(0, 255)));
      end
      repeat (gap_limit + 1) push_item(MODE_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic [15:0] gap,
                           input logic [7:0] hold, input logic squeeze);
    int start;
    begin
      set_config(gap, hold);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) begin
        @(posedge clk);
        hold_off = PRESSURE_CYCLES;
        @(negedge clk);
      end
      start = items_in;
      while (items_in - start < PHASE_ITEMS) send_frame();
      settle();
    end
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.frame_ok = out_tuser;
      got.channel_index = out_tdata[3:0];
      got.channel_value = out_tdata[14:4];
      got.failsafe_flag = out_tdata[15];
      got.lost_flag = out_tdata[16];
      got.valid_count = out_tdata[24:17];
      got.last_result = out_tlast;
      results_out++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected ok=%0d ch=%0d val=%0d fs=%0d lost=%0d hold=%0d last=%0d",
                 $time, got.frame_ok, got.channel_index, $signed(got.channel_value),
                 got.failsafe_flag, got.lost_flag, got.valid_count, got.last_result);
      end else begin
        want = pending_results.pop_front();
        if (got.frame_ok !== want.frame_ok || got.channel_index !== want.channel_index ||
            got.channel_value !== want.channel_value ||
            got.failsafe_flag !== want.failsafe_flag || got.lost_flag !== want.lost_flag ||
            got.valid_count !== want.valid_count || got.last_result !== want.last_result) begin
          mismatches++;
          $display("%0t: expected ok=%0d ch=%0d val=%0d fs=%0d lost=%0d hold=%0d last=%0d",
                   $time, want.frame_ok, want.channel_index, $signed(want.channel_value),
                   want.failsafe_flag, want.lost_flag, want.valid_count, want.last_result);
          $display("%0t:      got ok=%0d ch=%0d val=%0d fs=%0d lost=%0d hold=%0d last=%0d",
                   $time, got.frame_ok, got.channel_index, $signed(got.channel_value),
                   got.failsafe_flag, got.lost_flag, got.valid_count, got.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_BYTE;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_GAP;
    cfg_wdata = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    fill_idx = 0;
    idle_ticks = '0;
    hold_count = 8'h00;
    gap_limit = GAP_RESET;
    hold_load = HOLD_RESET;
    row_typed = 1'b0;
    row_want = '0;
    good_frames = 0;
    rejected_frames = 0;
    items_in = 0;
    results_out = 0;
    mismatches = 0;
    quiet_cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short frame after reset, a minimum-length frame at full scale, then a bad header.
    set_config(16'd1, 8'd255);
    dir_table.push_back(stim_row(MODE_BYTE, HDR_BYTE, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_TICK, 8'h00, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_TICK, 8'hFF, 1'b1, reject_result(8'd0)));
    dir_table.push_back(stim_row(MODE_BYTE, HDR_BYTE, 1'b0, '0));
    repeat (MIN_LEN - 1) dir_table.push_back(stim_row(MODE_BYTE, 8'hFF, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_TICK, 8'h00, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_TICK, 8'h00, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_BYTE, 8'hF0, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_TICK, 8'h00, 1'b0, '0));
    dir_table.push_back(stim_row(MODE_TICK, 8'h00, 1'b1, reject_result(8'd255)));
    // The receiver holds off while the table runs, so the decoded frame backs up the input.
    @(posedge clk);
    hold_off = PRESSURE_CYCLES;
    @(negedge clk);
    foreach (dir_table[i]) begin
      row_typed = dir_table[i].typed;
      row_want = dir_table[i].want;
      push_item(dir_table[i].mode, dir_table[i].data);
    end
    row_typed = 1'b0;
    settle();

    run_phase(0, 0, 16'd2, 8'd1, 1'b1);
    run_phase(53, 0, 16'd4, 8'd200, 1'b0);
    run_phase(0, 53, 16'd1, 8'($urandom_range(1, 255)), 1'b0);
    run_phase(35, 35, 16'($urandom_range(1, 6)), 8'($urandom_range(1, 254)), 1'b0);

    // With the largest gap setting no frame can close; lowering it later closes the open frame.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(16'hFFFF, 8'd1);
    push_item(MODE_BYTE, HDR_BYTE);
    repeat (8) push_item(MODE_TICK, 8'($urandom_range(0, 255)));
    settle();
    set_config(16'd3, 8'd255);
    push_item(MODE_TICK, 8'($urandom_range(0, 255)));
    settle();

    $display("Covered %0d items in and %0d results out: %0d decoded and %0d rejected frames.",
             items_in, results_out, good_frames, rejected_frames);
    $display("Pacing ran with and without gaps and stalls, long output %s",
             "hold-offs, and both register extremes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
